// ===== hdl/cpwq_pkg.sv =====
// Shared constants, register codes and status types for the coin pulse width qualifier.
package cpwq_pkg;

	localparam int CHANNELS_DEF        = 5;
	localparam int HIGH_SAMPLES_DEF    = 10;
	localparam int TIMEOUT_SAMPLES_DEF = 1000;
	localparam int COUNT_WIDTH_DEF     = 32;

	localparam int LINE_W      = 5;
	localparam int MIN_WIDTH_W = 10;
	localparam int CFG_DATA_W  = 10;
	localparam int LENGTH_W    = 10;
	localparam int CHANNEL_W   = 3;
	localparam int TOTAL_W     = 32;

	localparam logic [MIN_WIDTH_W-1:0] MIN_WIDTH_RESET = 10'd50;
	localparam logic [LINE_W-1:0]      ENABLE_RESET    = 5'd0;

	typedef enum logic [0:0] {
		REG_MIN_WIDTH      = 1'b0,
		REG_CHANNEL_ENABLE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic done;
		logic accepted;
	} cpwq_status_t;

endpackage

// ===== hdl/coin_pulse_width_qualifier.sv =====
// Top level of the coin pulse width qualifier: tick sweep, state memory and result queue.
// Each request is swept over the channels one per cycle through a read, update and write-back,
// unless a result waits on a stalled output. The input stalls until the last channel issues.
// The final result of a request passes through the holding register to the output register.
// Reset clears all control state at once; per-channel valid bits make unwritten entries
// read as their reset values, so no clearing pass is needed.
module coin_pulse_width_qualifier import cpwq_pkg::*; #(
	parameter int CHANNELS        = CHANNELS_DEF,
	parameter int HIGH_SAMPLES    = HIGH_SAMPLES_DEF,
	parameter int TIMEOUT_SAMPLES = TIMEOUT_SAMPLES_DEF,
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [LINE_W-1:0]      line_levels,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CHANNEL_W-1:0]   channel,
	output logic                   accepted,
	output logic [LENGTH_W-1:0]    pulse_length,
	output logic [TOTAL_W-1:0]     coin_total,
	output logic [TOTAL_W-1:0]     warning_total,
	output logic                   last_of_run
);

	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SAMPLE_W = $clog2(TIMEOUT_SAMPLES + 2);
	localparam int HIGH_W   = $clog2(HIGH_SAMPLES + 1);
	localparam int ENTRY_W  = 2 + 2 * SAMPLE_W + HIGH_W + 2 * COUNT_WIDTH;
	localparam int EXT_W    = 1 << CH_W;
	localparam logic [CH_W-1:0]    CH_LAST     = CH_W'(CHANNELS - 1);
	localparam logic [ENTRY_W-1:0] ENTRY_RESET = {1'b1, {(ENTRY_W - 1){1'b0}}};

	logic [MIN_WIDTH_W-1:0] min_width_q;
	logic [LINE_W-1:0]      channel_enable_q;
	logic [LINE_W-1:0]      lines_q;
	logic                   busy_q;
	logic [CH_W-1:0]        ch_q;
	logic [CHANNELS-1:0]    entry_valid_q;

	logic                   v_s2, level_s2, en_s2, last_s2, fwd_s2, valid_s2;
	logic [CH_W-1:0]        ch_s2;
	logic [ENTRY_W-1:0]     fwd_data_s2;

	logic                   hold_valid_q, hold_last_q, hold_accepted_q;
	logic [CHANNEL_W-1:0]   hold_channel_q;
	logic [LENGTH_W-1:0]    hold_length_q;
	logic [TOTAL_W-1:0]     hold_coin_q, hold_warn_q;

	logic [EXT_W-1:0]       lines_ext, enable_ext;
	logic                   rd_en, wr_en, adv, s2_go, out_free, hold_move;
	logic [ENTRY_W-1:0]     rd_data, entry_s2, entry_next;
	cpwq_status_t           status;
	logic [SAMPLE_W-1:0]    length;
	logic [COUNT_WIDTH-1:0] coin_next, warn_next;
	logic [CH_W+CHANNEL_W-1:0]        ch_ext;
	logic [SAMPLE_W+LENGTH_W-1:0]     len_ext;
	logic [COUNT_WIDTH+TOTAL_W-1:0]   coin_ext, warn_ext;

	assign lines_ext  = EXT_W'(lines_q);
	assign enable_ext = EXT_W'(channel_enable_q);
	assign in_stall   = busy_q;

	assign out_free  = !out_valid || !out_stall;
	assign s2_go     = !status.done || !hold_valid_q || out_free;
	assign adv       = !v_s2 || s2_go;
	assign rd_en     = busy_q && adv;
	assign wr_en     = v_s2 && s2_go;
	assign hold_move = hold_valid_q && out_free && (hold_last_q || (v_s2 && status.done));

	assign entry_s2 = fwd_s2 ? fwd_data_s2 : (valid_s2 ? rd_data : ENTRY_RESET);

	assign ch_ext   = (CH_W + CHANNEL_W)'(ch_s2);
	assign len_ext  = (SAMPLE_W + LENGTH_W)'(length);
	assign coin_ext = (COUNT_WIDTH + TOTAL_W)'(coin_next);
	assign warn_ext = (COUNT_WIDTH + TOTAL_W)'(warn_next);

	cpwq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CHANNELS)
	) u_state_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ch_s2),
		.wr_data(entry_next),
		.rd_en  (rd_en),
		.rd_addr(ch_q),
		.rd_data(rd_data)
	);

	cpwq_update #(
		.HIGH_SAMPLES   (HIGH_SAMPLES),
		.TIMEOUT_SAMPLES(TIMEOUT_SAMPLES),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_update (
		.entry     (entry_s2),
		.level     (level_s2),
		.enable    (en_s2),
		.min_width (min_width_q),
		.entry_next(entry_next),
		.status    (status),
		.length    (length),
		.coin_next (coin_next),
		.warn_next (warn_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q      <= MIN_WIDTH_RESET;
			channel_enable_q <= ENABLE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_WIDTH: begin
					min_width_q <= cfg_data[MIN_WIDTH_W-1:0];
				end
				REG_CHANNEL_ENABLE: begin
					channel_enable_q <= cfg_data[LINE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			ch_q          <= '0;
			v_s2          <= 1'b0;
			entry_valid_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
			end else if (rd_en) begin
				if (ch_q == CH_LAST) begin
					busy_q <= 1'b0;
				end else begin
					ch_q <= ch_q + CH_W'(1);
				end
			end
			if (rd_en) begin
				v_s2 <= 1'b1;
			end else if (s2_go) begin
				v_s2 <= 1'b0;
			end
			if (wr_en) begin
				entry_valid_q[ch_s2] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			lines_q <= line_levels;
		end
		if (rd_en) begin
			ch_s2       <= ch_q;
			level_s2    <= lines_ext[ch_q];
			en_s2       <= enable_ext[ch_q];
			last_s2     <= (ch_q == CH_LAST);
			fwd_s2      <= wr_en && (ch_s2 == ch_q);
			fwd_data_s2 <= entry_next;
			valid_s2    <= entry_valid_q[ch_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			hold_last_q  <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (wr_en && status.done) begin
				hold_valid_q <= 1'b1;
				hold_last_q  <= last_s2;
			end else if (hold_move) begin
				hold_valid_q <= 1'b0;
				hold_last_q  <= 1'b0;
			end else if (wr_en && last_s2 && hold_valid_q) begin
				hold_last_q <= 1'b1;
			end
			if (hold_move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && status.done) begin
			hold_channel_q  <= ch_ext[CHANNEL_W-1:0];
			hold_accepted_q <= status.accepted;
			hold_length_q   <= len_ext[LENGTH_W-1:0];
			hold_coin_q     <= coin_ext[TOTAL_W-1:0];
			hold_warn_q     <= warn_ext[TOTAL_W-1:0];
		end
		if (hold_move) begin
			channel       <= hold_channel_q;
			accepted      <= hold_accepted_q;
			pulse_length  <= hold_length_q;
			coin_total    <= hold_coin_q;
			warning_total <= hold_warn_q;
			last_of_run   <= hold_last_q;
		end
	end

	// The end-of-request mark only ever sits on a held result.
	assert property (@(posedge clk) disable iff (!arst_n) hold_last_q |-> hold_valid_q)
		else $error("end-of-request mark without a held result");

	assert property (@(posedge clk) disable iff (!arst_n) wr_en |-> (ch_s2 <= CH_LAST))
		else $error("state write beyond the last channel");

	// Issuing the last channel ends the sweep and loads it into the update stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && (ch_q == CH_LAST)) |=> (!busy_q && v_s2 && last_s2))
		else $error("sweep did not close after the last channel");

	// A result that finds the holding slot full only proceeds when the output can take it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && status.done && hold_valid_q) |-> hold_move)
		else $error("held result overwritten");

endmodule

// ===== hdl/cpwq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
module cpwq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/cpwq_update.sv =====
// Per-channel measurement update: edge arming, sample counting, qualification and counters.
module cpwq_update import cpwq_pkg::*; #(
	parameter int HIGH_SAMPLES    = HIGH_SAMPLES_DEF,
	parameter int TIMEOUT_SAMPLES = TIMEOUT_SAMPLES_DEF,
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
	localparam int SAMPLE_W = $clog2(TIMEOUT_SAMPLES + 2),
	localparam int HIGH_W   = $clog2(HIGH_SAMPLES + 1),
	localparam int ENTRY_W  = 2 + 2 * SAMPLE_W + HIGH_W + 2 * COUNT_WIDTH
) (
	input  logic [ENTRY_W-1:0]     entry,
	input  logic                   level,
	input  logic                   enable,
	input  logic [MIN_WIDTH_W-1:0] min_width,
	output logic [ENTRY_W-1:0]     entry_next,
	output cpwq_status_t           status,
	output logic [SAMPLE_W-1:0]    length,
	output logic [COUNT_WIDTH-1:0] coin_next,
	output logic [COUNT_WIDTH-1:0] warn_next
);

	localparam int CMP_W = SAMPLE_W + MIN_WIDTH_W;
	localparam logic [HIGH_W-1:0]   HIGH_LIMIT    = HIGH_W'(HIGH_SAMPLES);
	localparam logic [SAMPLE_W-1:0] TIMEOUT_LIMIT = SAMPLE_W'(TIMEOUT_SAMPLES);
	localparam logic [SAMPLE_W-1:0] TIMEOUT_LEN   = SAMPLE_W'(TIMEOUT_SAMPLES + 1);

	logic                   prev, meas;
	logic [SAMPLE_W-1:0]    sample, last_len;
	logic [HIGH_W-1:0]      high;
	logic [COUNT_WIDTH-1:0] coin, warn;

	logic                   prev_n, meas_n;
	logic [SAMPLE_W-1:0]    sample_n, last_len_n, sample_inc;
	logic [HIGH_W-1:0]      high_n, high_inc;

	assign {prev, meas, sample, high, coin, warn, last_len} = entry;
	assign entry_next = {prev_n, meas_n, sample_n, high_n, coin_next, warn_next, last_len_n};

	assign sample_inc = sample + SAMPLE_W'(1);
	assign high_inc   = high + HIGH_W'(level);

	always_comb begin
		prev_n       = level;
		meas_n       = meas;
		sample_n     = sample;
		high_n       = high;
		coin_next    = coin;
		warn_next    = warn;
		last_len_n   = last_len;
		status       = '0;
		length       = '0;
		if (meas) begin
			sample_n = sample_inc;
			high_n   = high_inc;
			if (high_inc >= HIGH_LIMIT) begin
				status.done = 1'b1;
				length      = sample_inc;
			end else if (sample_inc >= TIMEOUT_LIMIT) begin
				status.done = 1'b1;
				length      = TIMEOUT_LEN;
			end
			if (status.done) begin
				status.accepted = CMP_W'(length) >= CMP_W'(min_width);
				if (status.accepted) begin
					coin_next = (&coin) ? coin : coin + COUNT_WIDTH'(1);
				end else begin
					warn_next  = (&warn) ? warn : warn + COUNT_WIDTH'(1);
					last_len_n = length;
				end
				meas_n   = 1'b0;
				sample_n = '0;
				high_n   = '0;
			end
		end else if (enable && prev && !level) begin
			meas_n   = 1'b1;
			sample_n = '0;
			high_n   = '0;
		end
	end

endmodule
